// ----- src/nnu_pkg.sv -----
// nnu_pkg: shared types and constants for the nearest-neighbor upsampler
// no dependencies; imported by nearest_neighbor_upsampler and the testbench
package nnu_pkg;

  // configuration register widths, fixed by the register map
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int ROW_LEN_W   = 11;
  localparam int FACTOR_W    = 4;
  localparam int ROWS_W      = 11;

  // rows per plane saturate here; row counter width follows
  localparam int ROW_LIMIT   = 1024;
  localparam int ROW_CNT_W   = $clog2(ROW_LIMIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH     = 2'd0,
    REG_FACTOR         = 2'd1,
    REG_ROWS_PER_PLANE = 2'd2
  } cfg_reg_t;

  // per-request flags carried from the issue stage to the copy stage
  typedef struct packed {
    logic err;
    logic replay;
    logic last_col;
    logic last_rep;
    logic last_row;
  } job_flags_t;

endpackage

// ----- src/nearest_neighbor_upsampler.sv -----
// nearest_neighbor_upsampler: streaming 2-D nearest-neighbor upsampler, top level
// depends on nnu_pkg; holds the line store, phase counters and the copy stage
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   item     | item_valid/item_stall  | func, pixel_in
//   result   | result_valid/result_stall | pixel_out, last_copy, row_end, plane_end,
//            |                        |   phase_error
//   cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data (always ready)
//
// a request is taken into the issue register (line store written or read there), then the
// copy stage sends factor results, one per cycle unless result_stall holds it; a phase
// error sends one. the copy stage output port sets the rate; the first result passes
// through the issue register and then the copy stage register before it is offered.
// rst is synchronous; it clears counters, stage valids and restores register defaults.
// a stalled result holds the copy stage; the issue register keeps taking one request ahead.
module nearest_neighbor_upsampler
  import nnu_pkg::*;
#(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_FACTOR = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         func,
  input  logic signed [DATA_WIDTH-1:0] pixel_in,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [DATA_WIDTH-1:0] pixel_out,
  output logic                         last_copy,
  output logic                         row_end,
  output logic                         plane_end,
  output logic                         phase_error,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int FAC_W = $clog2(MAX_FACTOR);

  // configuration registers
  logic [ROW_LEN_W-1:0] row_length;
  logic [FACTOR_W-1:0]  factor;
  logic [ROWS_W-1:0]    rows_per_plane;

  // phase state
  logic [COL_W-1:0]     column_count;
  logic [FAC_W-1:0]     repeat_count;
  logic [ROW_CNT_W-1:0] row_count;

  logic [DATA_WIDTH-1:0] line_store [MAX_COLS];
  logic [DATA_WIDTH-1:0] rd_data;

  // issue stage
  logic                  a_valid;
  job_flags_t            a_flags;
  logic [DATA_WIDTH-1:0] a_pixel;
  logic [FAC_W-1:0]      a_cnt_m1;

  // copy stage
  logic                  b_valid;
  job_flags_t            b_flags;
  logic [DATA_WIDTH-1:0] b_pixel;
  logic [FAC_W-1:0]      b_cnt_m1;
  logic [FAC_W-1:0]      b_k;

  logic [COL_W-1:0]      len_m1;
  logic [FAC_W-1:0]      f_m1;
  logic [ROW_CNT_W-1:0]  rows_m1;
  logic                  in_accept, out_accept, a_move, b_last, b_free;
  logic                  replay, err, last_col, last_rep, last_row;
  job_flags_t            flags_next;

  // clamped register values, minus one
  always_comb begin
    if (row_length == '0)
      len_m1 = '0;
    else if (32'(row_length) > MAX_COLS)
      len_m1 = COL_W'(MAX_COLS - 1);
    else
      len_m1 = COL_W'(row_length - 1'b1);

    if (factor == '0)
      f_m1 = '0;
    else if (32'(factor) > MAX_FACTOR)
      f_m1 = FAC_W'(MAX_FACTOR - 1);
    else
      f_m1 = FAC_W'(factor - 1'b1);

    if (rows_per_plane == '0)
      rows_m1 = '0;
    else if (32'(rows_per_plane) > ROW_LIMIT)
      rows_m1 = ROW_CNT_W'(ROW_LIMIT - 1);
    else
      rows_m1 = ROW_CNT_W'(rows_per_plane - 1'b1);
  end

  always_comb begin
    replay   = repeat_count != '0;
    err      = func != replay;
    last_col = column_count >= len_m1;
    last_row = row_count >= rows_m1;
    last_rep = replay ? (repeat_count >= f_m1) : (f_m1 == '0);
    flags_next.err      = err;
    flags_next.replay   = replay;
    flags_next.last_col = last_col;
    flags_next.last_rep = last_rep;
    flags_next.last_row = last_row;
  end

  // handshakes
  assign b_last       = b_k == b_cnt_m1;
  assign out_accept   = b_valid && !result_stall;
  assign b_free       = !b_valid || (out_accept && b_last);
  assign a_move       = a_valid && b_free;
  assign item_stall   = a_valid && !a_move;
  assign in_accept    = item_valid && !item_stall;
  assign cfg_ready    = 1'b1;

  // config writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= ROW_LEN_W'(1024);
      factor         <= FACTOR_W'(2);
      rows_per_plane <= ROWS_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_LENGTH:     row_length     <= cfg_data[ROW_LEN_W-1:0];
        REG_FACTOR:         factor         <= cfg_data[FACTOR_W-1:0];
        REG_ROWS_PER_PLANE: rows_per_plane <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // phase counters advance on every good request
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      repeat_count <= '0;
      row_count    <= '0;
    end else if (in_accept && !err) begin
      if (!last_col) begin
        column_count <= column_count + 1'b1;
      end else begin
        column_count <= '0;
        if (last_rep) begin
          repeat_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          repeat_count <= repeat_count + 1'b1;
        end
      end
    end
  end

  // line store: new pixels write, replays read the same column
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!err && !replay)
        line_store[column_count] <= pixel_in;
      rd_data <= line_store[column_count];
    end
  end

  // issue register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_flags  <= flags_next;
      a_pixel  <= pixel_in;
      a_cnt_m1 <= err ? '0 : f_m1;
    end
  end

  // copy stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_k     <= '0;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_k     <= '0;
    end else if (out_accept) begin
      if (b_last)
        b_valid <= 1'b0;
      else
        b_k <= b_k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_flags  <= a_flags;
      b_cnt_m1 <= a_cnt_m1;
      if (a_flags.err)
        b_pixel <= '0;
      else if (a_flags.replay)
        b_pixel <= rd_data;
      else
        b_pixel <= a_pixel;
    end
  end

  assign result_valid = b_valid;
  assign pixel_out    = b_pixel;
  assign last_copy    = b_last;
  assign row_end      = b_last && !b_flags.err && b_flags.last_col;
  assign plane_end    = b_last && !b_flags.err && b_flags.last_col && b_flags.last_rep
                        && b_flags.last_row;
  assign phase_error  = b_flags.err;

  // error results are single, flagless and zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid && phase_error |-> last_copy && !row_end && !plane_end && pixel_out == '0)
    else $error("malformed phase error result");

  // copy index stays inside the request's copy count
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_k <= b_cnt_m1)
    else $error("copy counter overran");

  // the issue register only refills when it is empty or emptying
  assert property (@(posedge clk) disable iff (rst)
    in_accept && a_valid |-> a_move)
    else $error("issue register overwritten");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && plane_end |-> row_end && last_copy)
    else $error("plane end without row end");

endmodule

// ----- sim/testbench.sv -----
// testbench for nearest_neighbor_upsampler: directed and random requests, checked against
// a cycle-free predictor of the line store and counters kept in a small scoreboard class
// depends on nnu_pkg and nearest_neighbor_upsampler; needs nothing else
module testbench;
  import nnu_pkg::*;

  localparam int PIX_W      = 16;
  localparam int LINE_DEPTH = 1024;
  localparam int MAX_UP     = 8;
  localparam int RANDOM_REQ = 155;
  localparam int HOLD_LEN   = 120;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic signed [PIX_W-1:0] pixel;
    logic                    last_copy;
    logic                    row_end;
    logic                    plane_end;
    logic                    phase_error;
  } copy_t;

  class pixel_copy_board;
    logic [PIX_W-1:0] line_buf [LINE_DEPTH];
    int unsigned      col_idx;
    int unsigned      rep_idx;
    int unsigned      row_idx;
    logic [10:0]      row_len_reg;
    logic [3:0]       factor_reg;
    logic [10:0]      rows_reg;
    copy_t            pending_copies [$];
    int               errors;

    function new();
      col_idx     = 0;
      rep_idx     = 0;
      row_idx     = 0;
      row_len_reg = 11'd1024;
      factor_reg  = 4'd2;
      rows_reg    = 11'd1024;
      errors      = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_len();
      return clip(row_len_reg, LINE_DEPTH);
    endfunction

    function int pending();
      return pending_copies.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [10:0] v);
      case (idx)
        REG_ROW_LENGTH:     row_len_reg = v;
        REG_FACTOR:         factor_reg = v[3:0];
        REG_ROWS_PER_PLANE: rows_reg = v;
        default: ;
      endcase
    endfunction

    // expected copies for one accepted request, then counter update
    function void take_request(bit kind, logic [PIX_W-1:0] px);
      int unsigned      len, fac, rows, col;
      bit               replay, last_col, last_rep, last_row;
      logic [PIX_W-1:0] px_out;
      copy_t            c;
      len    = eff_len();
      fac    = clip(factor_reg, MAX_UP);
      rows   = clip(rows_reg, ROW_LIMIT);
      replay = (rep_idx != 0);
      if (kind != replay) begin
        c.pixel       = '0;
        c.last_copy   = 1'b1;
        c.row_end     = 1'b0;
        c.plane_end   = 1'b0;
        c.phase_error = 1'b1;
        pending_copies.push_back(c);
        return;
      end
      col      = (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
      last_col = (col >= len - 1);
      last_row = (row_idx >= rows - 1);
      if (!replay) begin
        line_buf[col] = px;
        px_out        = px;
        last_rep      = (fac == 1);
      end else begin
        px_out   = line_buf[col];
        last_rep = (rep_idx >= fac - 1);
      end
      for (int k = 0; k < fac; k++) begin
        c.pixel       = px_out;
        c.last_copy   = (k == fac - 1);
        c.row_end     = c.last_copy && last_col;
        c.plane_end   = c.row_end && last_rep && last_row;
        c.phase_error = 1'b0;
        pending_copies.push_back(c);
      end
      if (!last_col) begin
        col_idx = col + 1;
      end else begin
        col_idx = 0;
        if (last_rep) begin
          rep_idx = 0;
          row_idx = last_row ? 0 : row_idx + 1;
        end else begin
          rep_idx = (rep_idx + 1) & 7;
        end
      end
    endfunction

    function void compare_field(string label, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, label, want, got);
      end
    endfunction

    function void check_copy(logic signed [PIX_W-1:0] px, logic lc, logic re, logic pe,
                             logic err);
      copy_t want;
      if (pending_copies.size() == 0) begin
        errors++;
        $display("%0t mismatch: expected no result, actual pixel_out %0d", $time, px);
        return;
      end
      want = pending_copies.pop_front();
      compare_field("pixel_out", want.pixel, px);
      compare_field("last_copy", want.last_copy, lc);
      compare_field("row_end", want.row_end, re);
      compare_field("plane_end", want.plane_end, pe);
      compare_field("phase_error", want.phase_error, err);
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic                    func;
  logic signed [PIX_W-1:0] pixel_in;
  logic                    result_valid;
  logic                    result_stall;
  logic signed [PIX_W-1:0] pixel_out;
  logic                    last_copy;
  logic                    row_end;
  logic                    plane_end;
  logic                    phase_error;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  pixel_copy_board board = new();
  bit              steady_phase = 1'b0;
  bit              hold_req = 1'b0;
  int              cycles = 0;

  nearest_neighbor_upsampler u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_out    (pixel_out),
    .last_copy    (last_copy),
    .row_end      (row_end),
    .plane_end    (plane_end),
    .phase_error  (phase_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [10:0] pick_row_len(bit grow_ok, int unsigned cur);
    int r;
    r = $urandom_range(0, 9);
    // growing the row mid-stream would replay columns never stored
    if (!grow_ok) begin
      if (r == 0) return 11'd0;
      return 11'($urandom_range(1, (cur < 6) ? cur : 6));
    end
    if (r == 0) return 11'd0;
    if (r == 1) return 11'd2047;
    if (r == 2) return 11'($urandom_range(1000, 1100));
    return 11'($urandom_range(1, 6));
  endfunction

  function automatic logic [10:0] pick_factor();
    int          r;
    logic [3:0]  f;
    logic [6:0]  junk;
    r    = $urandom_range(0, 9);
    junk = 7'($urandom);
    if (r == 0) f = 4'd0;
    else if (r == 1) f = 4'($urandom_range(9, 15));
    else if (r == 2) f = 4'd8;
    else f = 4'($urandom_range(1, 4));
    return {junk, f};
  endfunction

  function automatic logic [10:0] pick_rows();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 11'd2047;
    if (r == 1) return 11'($urandom_range(1024, 1500));
    return 11'($urandom_range(0, 3));
  endfunction

  task automatic send_request(bit kind, logic signed [PIX_W-1:0] px);
    item_valid = 1'b1;
    func       = kind;
    pixel_in   = px;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    board.take_request(kind, px);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [10:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain every expected copy, then wait for the copy stage to go quiet
  task automatic settle();
    item_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : result_side
    int stall_left;
    stall_left   = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall)
        board.check_copy(pixel_out, last_copy, row_end, plane_end, phase_error);
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        result_stall = 1'b1;
        stall_left--;
      end else begin
        result_stall = 1'b0;
        if (!steady_phase && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin : stimulus
    int n_random;
    int phase;
    int plen;
    int g;
    bit kind;
    bit grow_ok;
    n_random   = 0;
    phase      = 0;
    rst        = 1'b1;
    item_valid = 1'b0;
    func       = 1'b0;
    pixel_in   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ROW_LENGTH;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // three-pixel rows, two rows per plane, one replay pass
    write_reg(REG_ROW_LENGTH, 11'd3);
    write_reg(REG_FACTOR, 11'd2);
    write_reg(REG_ROWS_PER_PLANE, 11'd2);
    send_request(1'b1, 16'sh1111);
    send_request(1'b0, 16'sh7fff);
    send_request(1'b0, 16'sh8000);
    send_request(1'b0, 16'sh0000);
    send_request(1'b0, 16'sh1234);
    repeat (3) send_request(1'b1, 16'($urandom));
    send_request(1'b0, -16'sd1);
    send_request(1'b0, 16'sd1);
    send_request(1'b0, 16'sh5555);
    repeat (3) send_request(1'b1, 16'($urandom));

    // factor zero acts as one: no replay phase at all
    settle();
    write_reg(REG_FACTOR, 11'd0);
    write_reg(REG_ROW_LENGTH, 11'd1);
    write_reg(REG_ROWS_PER_PLANE, 11'd1);
    send_request(1'b0, 16'($urandom));
    send_request(1'b1, 16'($urandom));
    send_request(1'b0, 16'($urandom));

    // all-ones writes saturate factor and rows per plane
    settle();
    write_reg(REG_FACTOR, 11'h7ff);
    write_reg(REG_ROWS_PER_PLANE, 11'h7ff);
    send_request(1'b0, 16'($urandom));
    repeat (7) send_request(1'b1, 16'($urandom));

    while (n_random < RANDOM_REQ) begin
      settle();
      grow_ok = (board.col_idx == 0 && board.rep_idx == 0);
      if ($urandom_range(0, 1))
        write_reg(REG_ROW_LENGTH, pick_row_len(grow_ok, board.eff_len()));
      if ($urandom_range(0, 1)) write_reg(REG_FACTOR, pick_factor());
      if ($urandom_range(0, 2) == 0) write_reg(REG_ROWS_PER_PLANE, pick_rows());
      steady_phase = ($urandom_range(0, 3) == 0) || (phase == 2);
      plen = $urandom_range(8, 30);
      for (int i = 0; i < plen; i++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 2 && i == 3) hold_req = 1'b1;
        if (phase == 4 && i == plen / 2) begin
          item_valid = 1'b0;
          while (board.pending() != 0) @(negedge clk);
        end
        if (!steady_phase) begin
          g = gap_len();
          if (g > 0) begin
            item_valid = 1'b0;
            repeat (g) @(negedge clk);
          end
        end
        kind = (board.rep_idx != 0);
        if ($urandom_range(0, 11) == 0) kind = !kind;
        send_request(kind, 16'($urandom));
        n_random++;
      end
      phase++;
    end

    item_valid   = 1'b0;
    steady_phase = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/nnu_pkg.sv
src/nearest_neighbor_upsampler.sv
sim/testbench.sv
